### sv/prefix_rolling_hash_mersenne61_unit_assert.svh
// Assertion macros shared by the rolling hash unit.
`ifndef PREFIX_ROLLING_HASH_MERSENNE61_UNIT_ASSERT_SVH
`define PREFIX_ROLLING_HASH_MERSENNE61_UNIT_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define RHM61_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The condition implies the expression in the following cycle.
`define RHM61_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### sv/rhm61_pkg.sv
// Shared types and constants of the rolling hash unit.
package rhm61_pkg;

    localparam int HASH_W    = 61;
    localparam int BASE_W    = 31;
    localparam int KIND_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 12;
    localparam int STATUS_W  = 2;
    localparam int HALF_W    = 32;
    localparam int PROD_W    = 2 * HALF_W;
    localparam int ACC_W     = 2 * HASH_W;
    localparam int IN_DATA_W = ((CHAR_W + 2 * IDX_W + 7) / 8) * 8;

    localparam logic [HASH_W-1:0] MOD61      = {HASH_W{1'b1}};
    localparam logic [BASE_W-1:0] BASE_RESET = 31'd1000003;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] product;
    } mul_rsp_t;

endpackage

### sv/rhm61_store.sv
// Hash store memory with a fixed entry zero and a registered read port.
module rhm61_store import rhm61_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter logic [HASH_W-1:0] ENTRY0 = 61'd0,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int LEN_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [LEN_W-1:0]  rd_addr,
    output logic [HASH_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [LEN_W-1:0]  wr_addr,
    input  logic [HASH_W-1:0] wr_data
);

    logic [HASH_W-1:0] mem [DEPTH];
    logic [HASH_W-1:0] data_reg;
    logic              zero_reg;
    logic [LEN_W-1:0]  rd_idx;
    logic [LEN_W-1:0]  wr_idx;

    // Entries one to DEPTH live in the array; entry zero is a constant.
    assign rd_idx = rd_addr - LEN_W'(1);
    assign wr_idx = wr_addr - LEN_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_idx[ADDR_W-1:0]];
            zero_reg <= (rd_addr == '0);
        end
    end

    assign rd_data = zero_reg ? ENTRY0 : data_reg;

endmodule

### sv/rhm61_mulmod.sv
// Iterative multiplier modulo 2^61-1 built on one 32x32 multiplier.
module rhm61_mulmod import rhm61_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    typedef enum logic [4:0] {
        MS_IDLE   = 5'b00001,
        MS_MUL    = 5'b00010,
        MS_DRAIN  = 5'b00100,
        MS_FOLD   = 5'b01000,
        MS_REDUCE = 5'b10000
    } mul_state_t;

    mul_state_t        state_reg;
    mul_state_t        state_next;
    logic [1:0]        step_reg;
    logic              pend_reg;
    logic              done_reg;
    logic [1:0]        shift_reg;
    logic [HASH_W-1:0] a_reg;
    logic [HASH_W-1:0] b_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [HASH_W:0]   fold_reg;
    logic [HASH_W-1:0] res_reg;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [ACC_W-1:0]  addend;
    logic [HASH_W:0]   fold_sum;
    logic [HASH_W-1:0] reduced;

    // Step bit one picks the upper half of a, step bit zero the upper half of b.
    assign op_a = step_reg[1] ? HALF_W'(a_reg >> HALF_W) : a_reg[HALF_W-1:0];
    assign op_b = step_reg[0] ? HALF_W'(b_reg >> HALF_W) : b_reg[HALF_W-1:0];

    always_comb
    begin
        case (shift_reg)
            2'd0:    addend = ACC_W'(prod_reg);
            2'd1:    addend = ACC_W'(prod_reg) << HALF_W;
            default: addend = ACC_W'(prod_reg) << (2 * HALF_W);
        endcase
        if (!pend_reg)
        begin
            addend = '0;
        end
    end

    assign fold_sum = {1'b0, fold_reg[HASH_W-1:0]} + (HASH_W + 1)'(fold_reg[HASH_W]);
    assign reduced  = (fold_sum >= {1'b0, MOD61}) ? HASH_W'(fold_sum - {1'b0, MOD61})
                                                  : fold_sum[HASH_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MS_IDLE:   if (req.start) state_next = MS_MUL;
            MS_MUL:    if (step_reg == 2'd3) state_next = MS_DRAIN;
            MS_DRAIN:  state_next = MS_FOLD;
            MS_FOLD:   state_next = MS_REDUCE;
            MS_REDUCE: state_next = MS_IDLE;
            default:   state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MS_REDUCE);
            if (state_reg == MS_IDLE)
            begin
                step_reg <= '0;
                pend_reg <= 1'b0;
            end
            else if (state_reg == MS_MUL)
            begin
                step_reg <= step_reg + 2'd1;
                pend_reg <= 1'b1;
            end
            else
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MS_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.a;
                    b_reg   <= req.b;
                    acc_reg <= '0;
                end
            end
            MS_MUL:
            begin
                prod_reg  <= op_a * op_b;
                shift_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
                acc_reg   <= acc_reg + addend;
            end
            MS_DRAIN:
            begin
                acc_reg <= acc_reg + addend;
            end
            MS_FOLD:
            begin
                fold_reg <= {1'b0, acc_reg[HASH_W-1:0]} + {1'b0, acc_reg[ACC_W-1:HASH_W]};
            end
            MS_REDUCE:
            begin
                res_reg <= reduced;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done    = done_reg;
    assign rsp.product = res_reg;

endmodule

### sv/prefix_rolling_hash_mersenne61_unit.sv
// Top level of the polynomial rolling hash unit modulo 2^61-1.
// One item at a time; a clear, a full append or a bad query goes straight to the result,
// a whole-string read takes one store read, a query one modular multiply and an append two.
// The next input transfer can come in the cycle after the result loads.
// An append runs two modular multiplies in turn on the shared 32x32 multiplier.
// Reset clears the length and the output valid flag and restores the base; stores need no pass.
`include "prefix_rolling_hash_mersenne61_unit_assert.svh"
module prefix_rolling_hash_mersenne61_unit import rhm61_pkg::*; #(
    parameter int MAX_LEN = 4096,
    localparam int LEN_W = $clog2(MAX_LEN + 1),
    localparam int OUT_DATA_W = ((HASH_W + LEN_W + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [BASE_W-1:0]     cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // char_code, left_index, right_index
    input  logic [KIND_W-1:0]     s_axis_tuser,   // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // hash_value, string_length
    output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

    localparam int CMP_W = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_MA   = 6'b000100,
        ST_WA   = 6'b001000,
        ST_WB   = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [IDX_W-1:0]    left_reg;
    logic [IDX_W-1:0]    right_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [HASH_W-1:0]   hv_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                out_valid_reg;
    logic [HASH_W-1:0]   out_hash_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic [KIND_W-1:0]   in_kind;
    logic [IDX_W-1:0]    in_left;
    logic [IDX_W-1:0]    in_right;
    logic                in_fire;
    logic                bad_query;
    logic                full;
    logic                out_load;
    logic [CMP_W-1:0]    left_ext;
    logic [CMP_W-1:0]    right_inc;
    logic [CMP_W-1:0]    span;
    logic                pre_rd_en;
    logic [LEN_W-1:0]    pre_rd_addr;
    logic [HASH_W-1:0]   pre_rd_data;
    logic                pow_rd_en;
    logic [LEN_W-1:0]    pow_rd_addr;
    logic [HASH_W-1:0]   pow_rd_data;
    logic                store_wr_en;
    logic [LEN_W-1:0]    store_wr_addr;
    logic [HASH_W:0]     add_sum;
    logic [HASH_W-1:0]   add_mod;
    logic [HASH_W-1:0]   sub_mod;
    mul_req_t            mul_req;
    mul_rsp_t            mul_rsp;

    assign in_kind  = s_axis_tuser;
    assign in_left  = s_axis_tdata[CHAR_W +: IDX_W];
    assign in_right = s_axis_tdata[CHAR_W + IDX_W +: IDX_W];
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    assign bad_query = (in_left > in_right) || (CMP_W'(in_right) >= CMP_W'(length_reg));
    assign full      = (length_reg == LEN_W'(MAX_LEN));

    assign left_ext  = CMP_W'(left_reg);
    assign right_inc = CMP_W'(right_reg) + CMP_W'(1);
    assign span      = right_inc - left_ext;

    assign out_load      = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);
    assign store_wr_addr = length_reg + LEN_W'(1);

    assign add_sum = {1'b0, mul_rsp.product} + (HASH_W + 1)'(char_reg);
    assign add_mod = (add_sum >= {1'b0, MOD61}) ? HASH_W'(add_sum - {1'b0, MOD61})
                                                : add_sum[HASH_W-1:0];
    assign sub_mod = (pre_rd_data >= mul_rsp.product) ? pre_rd_data - mul_rsp.product
                                                      : pre_rd_data + MOD61 - mul_rsp.product;

    always_comb
    begin
        state_next    = state_reg;
        pre_rd_en     = 1'b0;
        pre_rd_addr   = length_reg;
        pow_rd_en     = 1'b0;
        pow_rd_addr   = length_reg;
        store_wr_en   = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = pre_rd_data;
        mul_req.b     = HASH_W'(base_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_kind)
                        KIND_APPEND: state_next = full ? ST_FIN : ST_RD;
                        KIND_QUERY:  state_next = bad_query ? ST_FIN : ST_RD;
                        KIND_CLEAR:  state_next = ST_FIN;
                        default:     state_next = ST_RD;
                    endcase
                end
            end
            ST_RD:
            begin
                pre_rd_en = 1'b1;
                pow_rd_en = 1'b1;
                if (kind_reg == KIND_QUERY)
                begin
                    pre_rd_addr = left_ext[LEN_W-1:0];
                    pow_rd_addr = span[LEN_W-1:0];
                end
                state_next = ST_MA;
            end
            ST_MA:
            begin
                unique case (kind_reg)
                    KIND_APPEND:
                    begin
                        mul_req.start = 1'b1;
                        state_next    = ST_WA;
                    end
                    KIND_QUERY:
                    begin
                        mul_req.start = 1'b1;
                        mul_req.b     = pow_rd_data;
                        pre_rd_en     = 1'b1;
                        pre_rd_addr   = right_inc[LEN_W-1:0];
                        state_next    = ST_WA;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_WA:
            begin
                if (mul_rsp.done)
                begin
                    if (kind_reg == KIND_APPEND)
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = pow_rd_data;
                        state_next    = ST_WB;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_WB:
            begin
                if (mul_rsp.done)
                begin
                    store_wr_en = 1'b1;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_reg    <= '0;
            base_reg      <= BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            if (in_fire && (in_kind == KIND_CLEAR))
            begin
                length_reg <= '0;
            end
            else if (store_wr_en)
            begin
                length_reg <= length_reg + LEN_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= in_kind;
            char_reg  <= s_axis_tdata[CHAR_W-1:0];
            left_reg  <= in_left;
            right_reg <= in_right;
            hv_reg    <= '0;
            if ((in_kind == KIND_APPEND) && full)
            begin
                st_reg <= STATUS_FULL;
            end
            else if ((in_kind == KIND_QUERY) && bad_query)
            begin
                st_reg <= STATUS_BAD_INDEX;
            end
            else
            begin
                st_reg <= STATUS_OK;
            end
        end
        if ((state_reg == ST_MA) && (kind_reg != KIND_APPEND) && (kind_reg != KIND_QUERY))
        begin
            hv_reg <= pre_rd_data;
        end
        if ((state_reg == ST_WA) && mul_rsp.done)
        begin
            hv_reg <= (kind_reg == KIND_APPEND) ? add_mod : sub_mod;
        end
        if (out_load)
        begin
            out_hash_reg   <= hv_reg;
            out_status_reg <= st_reg;
            out_len_reg    <= length_reg;
        end
    end

    rhm61_store #(
        .DEPTH  (MAX_LEN),
        .ENTRY0 (61'd0)
    ) u_prefix_store (
        .clk     (clk),
        .rd_en   (pre_rd_en),
        .rd_addr (pre_rd_addr),
        .rd_data (pre_rd_data),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (hv_reg)
    );

    rhm61_store #(
        .DEPTH  (MAX_LEN),
        .ENTRY0 (61'd1)
    ) u_power_store (
        .clk     (clk),
        .rd_en   (pow_rd_en),
        .rd_addr (pow_rd_addr),
        .rd_data (pow_rd_data),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (mul_rsp.product)
    );

    rhm61_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_len_reg, out_hash_reg});
    assign m_axis_tuser  = out_status_reg;

    `RHM61_ASSERT_IMP(a_no_write_when_full, store_wr_en,
        length_reg != LEN_W'(MAX_LEN), "store written while full")
    `RHM61_ASSERT_NXT(a_length_steps, store_wr_en,
        length_reg == $past(length_reg) + LEN_W'(1),
        "length did not advance after a store write")
    `RHM61_ASSERT_IMP(a_error_hash_zero, out_valid_reg && (out_status_reg != STATUS_OK),
        out_hash_reg == '0, "error result carries a nonzero hash")
    `RHM61_ASSERT_IMP(a_hash_reduced, out_valid_reg,
        out_hash_reg != MOD61, "hash not reduced below the modulus")

endmodule
